// ===== hw/rtl/cksa_pkg.sv =====
// Shared constants, codes and types for the checkpoint segment allocator.
package cksa_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int ADDR_W       = 20;
	localparam int SIZE_W       = 16;
	localparam int META_W       = 8;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 20;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int LEN_W        = SIZE_W + 1;

	localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_COMMIT     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BEGIN      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ITER_FIRST = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ITER_NEXT  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_REGION_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_META     = 2'd2;

	localparam logic [META_W-1:0] META_RESET = 8'd4;

	typedef struct packed {
		logic              clr;
		logic              clr_side;
		logic              wr;
		logic              wr_side;
		logic [IDX_W-1:0]  wr_idx;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_side;
		logic [IDX_W-1:0]  rd_idx;
	} tbl_ctrl_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} tbl_rd_t;

endpackage

// ===== hw/rtl/cksa_cmd_if.sv =====
// Command channel: one beat carries one command and its payload size.
interface cksa_cmd_if;
	import cksa_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SIZE_W-1:0] size_bytes;

	modport source (output valid, output command, output size_bytes, input ready);
	modport sink (input valid, input command, input size_bytes, output ready);

endinterface

// ===== hw/rtl/cksa_rsp_if.sv =====
// Response channel: one beat carries one result of a command.
interface cksa_rsp_if;
	import cksa_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   segment_addr;
	logic [STATUS_W-1:0] status;
	logic                active_side;

	modport source (output valid, output segment_addr, output status, output active_side,
		input ready);
	modport sink (input valid, input segment_addr, input status, input active_side,
		output ready);

endinterface

// ===== hw/rtl/cksa_table.sv =====
// Two flop-based segment tables with per-entry valid bits and parallel clear.
module cksa_table (
	input  logic               clk,
	input  logic               arst_n,
	input  cksa_pkg::tbl_ctrl_t ctrl,
	output cksa_pkg::tbl_rd_t   rd
);
	import cksa_pkg::*;

	logic [MAX_SEGMENTS-1:0] val_a_q;
	logic [MAX_SEGMENTS-1:0] val_b_q;
	logic [ADDR_W-1:0]       addr_a_q [MAX_SEGMENTS];
	logic [ADDR_W-1:0]       addr_b_q [MAX_SEGMENTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_a_q <= '0;
			val_b_q <= '0;
		end else if (ctrl.clr) begin
			if (ctrl.clr_side) begin
				val_b_q <= '0;
			end else begin
				val_a_q <= '0;
			end
		end else if (ctrl.wr) begin
			if (ctrl.wr_side) begin
				val_b_q[ctrl.wr_idx] <= 1'b1;
			end else begin
				val_a_q[ctrl.wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr && !ctrl.clr) begin
			if (ctrl.wr_side) begin
				addr_b_q[ctrl.wr_idx] <= ctrl.wr_addr;
			end else begin
				addr_a_q[ctrl.wr_idx] <= ctrl.wr_addr;
			end
		end
	end

	always_comb begin
		if (ctrl.rd_side) begin
			rd.valid = val_b_q[ctrl.rd_idx];
			rd.addr  = addr_b_q[ctrl.rd_idx];
		end else begin
			rd.valid = val_a_q[ctrl.rd_idx];
			rd.addr  = addr_a_q[ctrl.rd_idx];
		end
	end

endmodule

// ===== hw/rtl/checkpoint_segment_allocator_unit.sv =====
// Top level of the double-buffered checkpoint segment allocator.
// An accepted command beat passes through the input register, then the result register,
// which drives the response beat. The state update and table access close together.
// Throughput: one command per cycle, unless a response held by rsp.ready stalls the flow.
// Reset: arst_n clears both tables' valid bits, side A working, bump pointer and
// region bases zero, metadata size 4; no clearing pass is needed.
module checkpoint_segment_allocator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	cksa_cmd_if.sink                       cmd,
	cksa_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [cksa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cksa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cksa_pkg::*;

	logic                s1_valid;
	logic [CMD_W-1:0]    cmd_s1;
	logic [SIZE_W-1:0]   size_s1;
	logic                adv;

	logic                rsp_valid_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [STATUS_W-1:0] status_q;
	logic                rsp_side_q;

	logic                side_q;
	logic [ADDR_W-1:0]   alloc_end_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    cursor_q;
	logic [ADDR_W-1:0]   region_a_q;
	logic [ADDR_W-1:0]   region_b_q;
	logic [META_W-1:0]   meta_q;

	logic                side_d;
	logic [ADDR_W-1:0]   alloc_end_d;
	logic [CNT_W-1:0]    fill_d;
	logic [CNT_W-1:0]    cursor_d;
	logic [ADDR_W-1:0]   addr_d;
	logic [STATUS_W-1:0] status_d;

	logic                full;
	logic [LEN_W-1:0]    seg_len;
	logic [CNT_W-1:0]    cursor_inc;
	logic [CNT_W-1:0]    rd_pos;
	logic                rd_in_range;

	tbl_ctrl_t           tctrl;
	tbl_rd_t             trd;

	assign adv       = s1_valid && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1  <= cmd.command;
			size_s1 <= cmd.size_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_a_q <= '0;
			region_b_q <= '0;
			meta_q     <= META_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REGION_A: region_a_q <= cfg_data[ADDR_W-1:0];
				REG_REGION_B: region_b_q <= cfg_data[ADDR_W-1:0];
				REG_META:     meta_q     <= cfg_data[META_W-1:0];
				default: ;
			endcase
		end
	end

	assign full        = fill_q >= CNT_W'(MAX_SEGMENTS);
	assign seg_len     = LEN_W'(size_s1) + LEN_W'(size_s1[0]) + LEN_W'(meta_q);
	assign cursor_inc  = (cursor_q >= CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
		: cursor_q + 1'b1;
	assign rd_pos      = (cmd_s1 == CMD_ITER_FIRST) ? '0 : cursor_inc;
	assign rd_in_range = rd_pos < CNT_W'(MAX_SEGMENTS);

	always_comb begin
		side_d      = side_q;
		alloc_end_d = alloc_end_q;
		fill_d      = fill_q;
		cursor_d    = cursor_q;
		addr_d      = '0;
		status_d    = ST_OK;
		tctrl       = '0;
		tctrl.rd_side = ~side_q;
		tctrl.rd_idx  = rd_pos[IDX_W-1:0];
		tctrl.wr_side = side_q;
		tctrl.wr_idx  = fill_q[IDX_W-1:0];
		tctrl.wr_addr = alloc_end_q;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					addr_d      = alloc_end_q;
					alloc_end_d = alloc_end_q + ADDR_W'(seg_len);
					fill_d      = fill_q + 1'b1;
					tctrl.wr    = 1'b1;
				end
			end
			CMD_COMMIT, CMD_BEGIN: begin
				side_d         = (cmd_s1 == CMD_COMMIT) ? ~side_q : side_q;
				alloc_end_d    = side_d ? region_b_q : region_a_q;
				fill_d         = '0;
				tctrl.clr      = 1'b1;
				tctrl.clr_side = side_d;
			end
			CMD_ITER_FIRST, CMD_ITER_NEXT: begin
				cursor_d = rd_pos;
				if (rd_in_range && trd.valid) begin
					addr_d = trd.addr;
				end else begin
					status_d = ST_NONE;
				end
			end
			default: ;
		endcase
		if (!adv) begin
			tctrl.clr = 1'b0;
			tctrl.wr  = 1'b0;
		end
	end

	cksa_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tctrl),
		.rd     (trd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q      <= 1'b0;
			alloc_end_q <= '0;
			fill_q      <= '0;
			cursor_q    <= '0;
		end else if (adv) begin
			side_q      <= side_d;
			alloc_end_q <= alloc_end_d;
			fill_q      <= fill_d;
			cursor_q    <= cursor_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_q     <= addr_d;
			status_q   <= status_d;
			rsp_side_q <= side_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.segment_addr = addr_q;
	assign rsp.status       = status_q;
	assign rsp.active_side  = rsp_side_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_SEGMENTS))
		else $error("fill count above table depth");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CNT_W'(MAX_SEGMENTS))
		else $error("iterate cursor above table depth");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1 == CMD_ALLOC && !full |=> fill_q == $past(fill_q) + 1'b1)
		else $error("alloc did not advance fill count");

	a_commit_flip: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1 == CMD_COMMIT |=> side_q != $past(side_q) && fill_q == '0)
		else $error("commit did not toggle side and reset fill count");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_FULL |-> addr_q == '0)
		else $error("full response carries an address");

endmodule
